/* rtl/core/xcc_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 update for the XOR cipher block.
package xcc_pkg;

  // Key and IV geometry.
  localparam int MAX_KEY_BYTES = 8;
  localparam int KEY_POS_W     = 3;
  localparam int KEY_LEN_W     = 4;
  localparam int IV_POS_W      = 2;

  // Standard reflected CRC-32 constants.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Stream widths.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DECRYPT_MODE = 3'd0,
    CFG_KEY_BYTES    = 3'd1,
    CFG_KEY_LENGTH   = 3'd2,
    CFG_IV_WORD      = 3'd3,
    CFG_CHECK_CRC    = 3'd4
  } cfg_idx_t;

  // Current register contents, handed from the register file to the datapath.
  typedef struct packed {
    logic                 decrypt_mode;
    logic [63:0]          key_bytes;
    logic [KEY_LEN_W-1:0] key_length;
    logic [31:0]          iv_word;
    logic [31:0]          check_crc;
  } cfg_t;

  // One result word before it is packed onto the output stream.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [31:0] crc_value;
    logic        crc_match;
  } result_t;

  // Fold one byte into a running reflected CRC-32, one bit per step.
  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/xcc_cfg_regs.sv */
// Configuration register file written through the plain write port.
module xcc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [xcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xcc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output xcc_pkg::cfg_t                   cfg
);

  xcc_pkg::cfg_t cfg_r;
  xcc_pkg::cfg_t cfg_nxt;

  // Decode the index and keep only the low bits that each register holds.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (xcc_pkg::cfg_idx_t'(cfg_index))
        xcc_pkg::CFG_DECRYPT_MODE: cfg_nxt.decrypt_mode = cfg_wdata[0];
        xcc_pkg::CFG_KEY_BYTES:    cfg_nxt.key_bytes    = cfg_wdata[63:0];
        xcc_pkg::CFG_KEY_LENGTH:   cfg_nxt.key_length   = cfg_wdata[xcc_pkg::KEY_LEN_W-1:0];
        xcc_pkg::CFG_IV_WORD:      cfg_nxt.iv_word      = cfg_wdata[31:0];
        xcc_pkg::CFG_CHECK_CRC:    cfg_nxt.check_crc    = cfg_wdata[31:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  // Registers return to their documented reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decrypt_mode <= 1'b0;
      cfg_r.key_bytes    <= 64'd0;
      cfg_r.key_length   <= xcc_pkg::KEY_LEN_W'(1);
      cfg_r.iv_word      <= 32'd0;
      cfg_r.check_crc    <= 32'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/xcc_cipher_core.sv */
// Input register, message state and the single-pass XOR and CRC-32 datapath.
module xcc_cipher_core (
  input  logic             clk,
  input  logic             rst_n,
  input  xcc_pkg::cfg_t    cfg,
  input  logic             in_valid,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last,
  output logic             in_ready,
  input  logic             res_ready,
  output logic             res_valid,
  output xcc_pkg::result_t res
);

  // Input register.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_data_r;
  logic       s1_last_r;

  // Message state.
  logic [31:0]                  running_crc_r, running_crc_nxt;
  logic [xcc_pkg::KEY_POS_W-1:0] key_pos_r, key_pos_nxt;
  logic [xcc_pkg::IV_POS_W-1:0]  iv_pos_r, iv_pos_nxt;

  logic                          advance;
  logic [xcc_pkg::KEY_LEN_W-1:0] klen;
  logic [xcc_pkg::KEY_POS_W-1:0] kpos;
  logic [xcc_pkg::KEY_LEN_W-1:0] kpos_inc;
  logic [7:0]                    kbyte, ibyte, xored_byte, crc_byte;
  logic [31:0]                   crc_upd, crc_fin;

  // The held word moves on whenever the result register can take it.
  assign advance  = s1_valid_r && res_ready;
  assign in_ready = !s1_valid_r || res_ready;

  // Effective key length: zero counts as one, anything past the maximum as the maximum.
  always_comb begin
    priority if (cfg.key_length == '0) begin
      klen = xcc_pkg::KEY_LEN_W'(1);
    end else if (cfg.key_length > xcc_pkg::KEY_LEN_W'(xcc_pkg::MAX_KEY_BYTES)) begin
      klen = xcc_pkg::KEY_LEN_W'(xcc_pkg::MAX_KEY_BYTES);
    end else begin
      klen = cfg.key_length;
    end
  end

  // A position left beyond a shortened key falls back to key byte 0.
  assign kpos = ({1'b0, key_pos_r} >= klen) ? '0 : key_pos_r;

  // Keystream byte selection and the cipher itself.
  assign kbyte      = cfg.key_bytes[{kpos, 3'b000} +: 8];
  assign ibyte      = cfg.iv_word[{iv_pos_r, 3'b000} +: 8];
  assign xored_byte = s1_data_r ^ kbyte ^ ibyte;

  // The CRC always covers the plaintext side of the stream.
  assign crc_byte = cfg.decrypt_mode ? xored_byte : s1_data_r;
  assign crc_upd  = xcc_pkg::crc_update(running_crc_r, crc_byte);
  assign crc_fin  = crc_upd ^ xcc_pkg::CRC_ONES;

  // Result word handed to the output register.
  assign res_valid     = advance;
  assign res.out_byte  = xored_byte;
  assign res.out_last  = s1_last_r;
  assign res.crc_value = crc_fin;
  assign res.crc_match = s1_last_r && cfg.decrypt_mode && (crc_fin == cfg.check_crc);

  assign kpos_inc = {1'b0, kpos} + xcc_pkg::KEY_LEN_W'(1);

  // Next message state: advance positions, or start over after the last byte.
  always_comb begin
    running_crc_nxt = running_crc_r;
    key_pos_nxt     = key_pos_r;
    iv_pos_nxt      = iv_pos_r;
    if (advance) begin
      if (s1_last_r) begin
        running_crc_nxt = xcc_pkg::CRC_ONES;
        key_pos_nxt     = '0;
        iv_pos_nxt      = '0;
      end else begin
        running_crc_nxt = crc_upd;
        key_pos_nxt     = (kpos_inc >= klen) ? '0 : kpos_inc[xcc_pkg::KEY_POS_W-1:0];
        iv_pos_nxt      = iv_pos_r + xcc_pkg::IV_POS_W'(1);
      end
    end
  end

  // Input register occupancy.
  always_comb begin
    priority if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      running_crc_r <= xcc_pkg::CRC_ONES;
      key_pos_r     <= '0;
      iv_pos_r      <= '0;
    end else begin
      s1_valid_r    <= s1_valid_nxt;
      running_crc_r <= running_crc_nxt;
      key_pos_r     <= key_pos_nxt;
      iv_pos_r      <= iv_pos_nxt;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last;
    end
  end

endmodule

/* rtl/core/xcc_out_stage.sv */
// Result register that drives the output stream.
module xcc_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            res_valid,
  input  xcc_pkg::result_t                res,
  output logic                            res_ready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [xcc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  logic             out_valid_r, out_valid_nxt;
  xcc_pkg::result_t out_res_r;

  // The register can load when empty or when its word leaves this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    priority if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  // Pack the result word, lowest field first, zero filled to whole bytes.
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.out_last;
  assign out_tdata  = {7'd0, out_res_r.crc_match, out_res_r.crc_value, out_res_r.out_byte};

endmodule

/* rtl/core/xor_iv_cipher_with_crc32_check.sv */
// Top level of the XOR stream cipher with IV and CRC-32 check.
// Each input word carries one message byte; it leaves XORed with the selected key
// byte and IV byte, together with the finalized CRC-32 of the plaintext so far and,
// on the last byte of a decrypted message, a match flag against the check CRC register.
// The block takes one byte per clock cycle unless a low out_tready stalls it. Each
// accepted byte passes through the input register, where the XOR and the byte-wide
// CRC update run, and then the result register. The byte-wide CRC feedback loop
// closes on the running CRC register. in_tready drops only while both registers
// hold words and out_tready is low. Write the configuration registers only while
// no message byte is in flight.
module xor_iv_cipher_with_crc32_check (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [xcc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xcc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [xcc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                            in_tlast,   // last
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [xcc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] out_byte, [39:8] crc_value,
                                                      // [40] crc_match, [47:41] zero
  output logic                            out_tlast   // out_last
);

  xcc_pkg::cfg_t    cfg;
  xcc_pkg::result_t res;
  logic             res_valid;
  logic             res_ready;

  // Configuration registers.
  xcc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register and single-pass datapath.
  xcc_cipher_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_tvalid),
    .in_data_byte (in_tdata[7:0]),
    .in_last      (in_tlast),
    .in_ready     (in_tready),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Result register.
  xcc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
